/* src/assert_macros.svh */
// assertion macros shared by the meter ballistics rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define MBBM_ASSERT(lbl, prop, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mbbm assertion failed");

// checked on every clock edge, reset included
`define MBBM_ASSERT_ALWAYS(lbl, prop, clk) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mbbm assertion failed");

`endif

/* src/mbbm_pkg.sv */
// shared types and constants of the meter ballistics and breakpoint map
// no dependencies
`default_nettype none

package mbbm_pkg;

  localparam int unsigned TableDepthDef = 16;

  localparam int unsigned CoeffW   = 17;
  localparam int unsigned EntriesW = 5;

  localparam logic [CoeffW-1:0] CoeffFull = 17'h10000;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_PRESET = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] level;
    logic [3:0]         entry_index;
    logic signed [15:0] entry_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] needle_angle;
    logic signed [15:0] smoothed_out;
    logic               level_changed;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_PRESET,
    CMD_WRITE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic signed [15:0] level;
    logic [3:0]         entry_index;
    logic signed [15:0] entry_angle;
  } cmd_t;

  typedef struct packed {
    logic [CoeffW-1:0]   coeff;
    logic [EntriesW-1:0] entries;
  } cfg_t;

endpackage

`default_nettype wire

/* src/mbbm_front.sv */
// front end: accepts input items, drops unused ones, queues commands
// depends on mbbm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module mbbm_front #(
  parameter int unsigned TABLE_DEPTH = mbbm_pkg::TableDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire mbbm_pkg::in_item_t in_item_i,
  output logic                   in_stall_o,
  output logic                   cmd_valid_o,
  output mbbm_pkg::cmd_t         cmd_o,
  input  wire logic              cmd_pop_i
);

  localparam int unsigned QDepth = 2;

  mbbm_pkg::cmd_t slot_q [QDepth];
  mbbm_pkg::cmd_t cmd_new;
  logic [1:0]     count_q, count_d;
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic           keep, push, pop;

  // classify
  always_comb begin
    keep                = 1'b0;
    cmd_new.kind        = mbbm_pkg::CMD_TICK;
    cmd_new.level       = in_item_i.level;
    cmd_new.entry_index = in_item_i.entry_index;
    cmd_new.entry_angle = in_item_i.entry_angle;
    unique case (in_item_i.opcode)
      mbbm_pkg::OP_TICK: begin
        keep         = 1'b1;
        cmd_new.kind = mbbm_pkg::CMD_TICK;
      end
      mbbm_pkg::OP_PRESET: begin
        keep         = 1'b1;
        cmd_new.kind = mbbm_pkg::CMD_PRESET;
      end
      mbbm_pkg::OP_WRITE: begin
        keep         = (32'(in_item_i.entry_index) < TABLE_DEPTH);
        cmd_new.kind = mbbm_pkg::CMD_WRITE;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o  = (count_q == 2'(QDepth));
  assign push        = in_valid_i & ~in_stall_o & keep;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_pop_i & cmd_valid_o;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    count_d  = count_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

  `MBBM_ASSERT(a_count_range, count_q <= 2'(QDepth), clk_i, rst_ni)
  `MBBM_ASSERT(a_count_pop, (pop && !push) |=> (count_q == $past(count_q) - 2'd1), clk_i, rst_ni)

endmodule

`default_nettype wire

/* src/mbbm_back.sv */
// back end: breakpoint table, one-pole smoothing, table walk and serial divide
// depends on mbbm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module mbbm_back #(
  parameter int unsigned TABLE_DEPTH = mbbm_pkg::TableDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mbbm_pkg::cfg_t    cfg_i,
  input  wire logic              cmd_valid_i,
  input  wire mbbm_pkg::cmd_t    cmd_i,
  output logic                   cmd_pop_o,
  output logic                   out_valid_o,
  output mbbm_pkg::out_item_t    out_item_o,
  input  wire logic              out_stall_i
);

  localparam int unsigned IdxW     = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DivSteps = 16;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MUL  = 10'b0000000010,
    S_UPD  = 10'b0000000100,
    S_CHK0 = 10'b0000001000,
    S_CHKN = 10'b0000010000,
    S_SCAN = 10'b0000100000,
    S_IMUL = 10'b0001000000,
    S_DIV  = 10'b0010000000,
    S_FIN  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] mem_q [TABLE_DEPTH];
  logic [31:0] rd_data_q;
  logic        mem_we;
  logic [IdxW-1:0] wr_addr, rd_addr;

  logic signed [23:0] smooth_q, smooth_d;
  logic signed [23:0] target_q, target_d;
  logic               preset_q, preset_d;
  logic signed [41:0] prod_q, prod_d;
  logic               changed_q, changed_d;
  logic [CntW-1:0]    n_q, n_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic signed [15:0] prev_lvl_q, prev_lvl_d;
  logic signed [15:0] prev_ang_q, prev_ang_d;
  logic signed [15:0] angle_q, angle_d;
  logic [23:0]        ip_diff_q, ip_diff_d;
  logic [15:0]        ip_mag_q, ip_mag_d;
  logic               neg_q, neg_d;
  logic [23:0]        den_q, den_d;
  logic [23:0]        rem_q, rem_d;
  logic [15:0]        numlo_q, numlo_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic               out_valid_q, out_valid_d;
  mbbm_pkg::out_item_t out_item_q, out_item_d;

  logic signed [24:0] diff25;
  logic signed [16:0] coeff_s;
  logic signed [41:0] mul_res;
  logic signed [41:0] shifted;
  logic signed [23:0] upd_val;
  logic               use_target;
  logic [CntW-1:0]    n_lim;
  logic [IdxW-1:0]    last_addr;
  logic signed [15:0] rd_lvl, rd_ang;
  logic signed [23:0] lvl_x;
  logic               le_hit, ge_hit, idx_last;
  logic signed [16:0] span, delta, mag17;
  logic [39:0]        iprod;
  logic [24:0]        trial;
  logic               trial_ge;
  logic [17:0]        qext, fin_sum;

  assign diff25     = {target_q[23], target_q} - {smooth_q[23], smooth_q};
  assign coeff_s    = $signed({1'b0, cfg_i.coeff[15:0]});
  assign mul_res    = diff25 * coeff_s;
  assign shifted    = prod_q >>> 16;
  assign use_target = preset_q | (cfg_i.coeff >= mbbm_pkg::CoeffFull);
  assign upd_val    = use_target ? target_q : smooth_q + $signed(shifted[23:0]);

  assign n_lim     = (32'(cfg_i.entries) > TABLE_DEPTH) ? CntW'(TABLE_DEPTH)
                                                        : CntW'(cfg_i.entries);
  assign last_addr = IdxW'(n_q - CntW'(1));
  assign idx_last  = (CntW'(idx_q) == n_q - CntW'(1));

  assign rd_lvl = $signed(rd_data_q[31:16]);
  assign rd_ang = $signed(rd_data_q[15:0]);
  assign lvl_x  = $signed({rd_lvl, 8'h00});
  assign le_hit = (smooth_q <= lvl_x);
  assign ge_hit = (smooth_q >= lvl_x);

  assign span  = {rd_lvl[15], rd_lvl} - {prev_lvl_q[15], prev_lvl_q};
  assign delta = {rd_ang[15], rd_ang} - {prev_ang_q[15], prev_ang_q};
  assign mag17 = delta[16] ? -delta : delta;

  assign iprod    = 40'(ip_diff_q) * 40'(ip_mag_q);
  assign trial    = {rem_q, numlo_q[15]};
  assign trial_ge = (trial >= {1'b0, den_q});
  assign qext     = {2'b00, numlo_q};
  assign fin_sum  = {{2{prev_ang_q[15]}}, prev_ang_q} + (neg_q ? 18'd0 - qext : qext);

  assign wr_addr = IdxW'(cmd_i.entry_index);

  always_comb begin
    state_d     = state_q;
    smooth_d    = smooth_q;
    target_d    = target_q;
    preset_d    = preset_q;
    prod_d      = prod_q;
    changed_d   = changed_q;
    n_d         = n_q;
    idx_d       = idx_q;
    prev_lvl_d  = prev_lvl_q;
    prev_ang_d  = prev_ang_q;
    angle_d     = angle_q;
    ip_diff_d   = ip_diff_q;
    ip_mag_d    = ip_mag_q;
    neg_d       = neg_q;
    den_d       = den_q;
    rem_d       = rem_q;
    numlo_d     = numlo_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_item_d  = out_item_q;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    rd_addr     = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == mbbm_pkg::CMD_WRITE) begin
            mem_we = 1'b1;
          end else begin
            target_d = $signed({cmd_i.level, 8'h00});
            preset_d = (cmd_i.kind == mbbm_pkg::CMD_PRESET);
            state_d  = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_d  = mul_res;
        state_d = S_UPD;
      end
      S_UPD: begin
        smooth_d  = upd_val;
        changed_d = (upd_val != smooth_q);
        n_d       = n_lim;
        rd_addr   = '0;
        if (n_lim == '0) begin
          angle_d = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_CHK0;
        end
      end
      S_CHK0: begin
        if (le_hit) begin
          angle_d = rd_ang;
          state_d = S_DONE;
        end else begin
          prev_lvl_d = rd_lvl;
          prev_ang_d = rd_ang;
          rd_addr    = last_addr;
          state_d    = S_CHKN;
        end
      end
      S_CHKN: begin
        if (ge_hit) begin
          angle_d = rd_ang;
          state_d = S_DONE;
        end else begin
          idx_d   = IdxW'(1);
          rd_addr = IdxW'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (le_hit) begin
          if (span[16] || span == '0) begin
            angle_d = prev_ang_q;
            state_d = S_DONE;
          end else begin
            ip_diff_d = 24'(smooth_q - $signed({prev_lvl_q, 8'h00}));
            ip_mag_d  = mag17[15:0];
            neg_d     = delta[16];
            den_d     = {span[15:0], 8'h00};
            state_d   = S_IMUL;
          end
        end else if (idx_last) begin
          angle_d = rd_ang;
          state_d = S_DONE;
        end else begin
          prev_lvl_d = rd_lvl;
          prev_ang_d = rd_ang;
          idx_d      = idx_q + IdxW'(1);
          rd_addr    = idx_q + IdxW'(1);
        end
      end
      S_IMUL: begin
        rem_d     = iprod[39:16];
        numlo_d   = iprod[15:0];
        div_cnt_d = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        rem_d     = trial_ge ? 24'(trial - {1'b0, den_q}) : trial[23:0];
        numlo_d   = {numlo_q[14:0], trial_ge};
        div_cnt_d = div_cnt_q + DivCntW'(1);
        if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        angle_d = $signed(fin_sum[15:0]);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d              = 1'b1;
          out_item_d.needle_angle  = angle_q;
          out_item_d.smoothed_out  = smooth_q[23:8];
          out_item_d.level_changed = changed_q;
          state_d                  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      smooth_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      smooth_q    <= smooth_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q   <= target_d;
    preset_q   <= preset_d;
    prod_q     <= prod_d;
    changed_q  <= changed_d;
    n_q        <= n_d;
    idx_q      <= idx_d;
    prev_lvl_q <= prev_lvl_d;
    prev_ang_q <= prev_ang_d;
    angle_q    <= angle_d;
    ip_diff_q  <= ip_diff_d;
    ip_mag_q   <= ip_mag_d;
    neg_q      <= neg_d;
    den_q      <= den_d;
    rem_q      <= rem_d;
    numlo_q    <= numlo_d;
    div_cnt_q  <= div_cnt_d;
    out_item_q <= out_item_d;
  end

  // breakpoint table, level in the upper half, angle in the lower half
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= {cmd_i.level, cmd_i.entry_angle};
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `MBBM_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), clk_i, rst_ni)
  `MBBM_ASSERT(a_smooth_only_upd, (state_q != S_UPD) |=> $stable(smooth_q), clk_i, rst_ni)
  `MBBM_ASSERT(a_quot_bound, (state_q == S_FIN) |-> (numlo_q <= ip_mag_q), clk_i, rst_ni)

endmodule

`default_nettype wire

/* src/meter_ballistics_breakpoint_map.sv */
// tick or preset: multiply and update, then go straight to output for an empty table, else check
// both ends and clamp, or walk the entries (one entry a cycle), then multiply and run a 16-step divide
// the back end takes one tick or preset at a time
// table write: handled in the back end, no result; unused opcodes are dropped
// the front queue holds 2 items; reset clears the smoothed level, sets the coefficient
// to full scale and clears the entry count; breakpoint contents are undefined until written
`default_nettype none

module meter_ballistics_breakpoint_map #(
  parameter int unsigned TABLE_DEPTH = mbbm_pkg::TableDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire mbbm_pkg::in_item_t in_item_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output mbbm_pkg::out_item_t    out_item_o,
  input  wire logic              out_stall_i,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam logic REG_COEFF   = 1'b0;
  localparam logic REG_ENTRIES = 1'b1;

  logic [mbbm_pkg::CoeffW-1:0]   coeff_q;
  logic [mbbm_pkg::EntriesW-1:0] entries_q;
  logic                          wr_en;
  mbbm_pkg::cfg_t                cfg;
  logic                          cmd_valid, cmd_pop;
  mbbm_pkg::cmd_t                cmd;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q   <= mbbm_pkg::CoeffFull;
      entries_q <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_COEFF:   coeff_q   <= pwdata[mbbm_pkg::CoeffW-1:0];
        REG_ENTRIES: entries_q <= pwdata[mbbm_pkg::EntriesW-1:0];
        default:     coeff_q   <= coeff_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COEFF:   prdata = 32'(coeff_q);
      REG_ENTRIES: prdata = 32'(entries_q);
      default:     prdata = '0;
    endcase
  end

  assign cfg.coeff   = coeff_q;
  assign cfg.entries = entries_q;

  mbbm_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  mbbm_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .out_stall_i(out_stall_i)
  );

endmodule

`default_nettype wire
